// ===== sv/skcd_pkg.sv =====
// Shared types and constants for the keypoint decode unit.
// No dependencies; imported by every module of the block.
package skcd_pkg;

    localparam int SKCD_MAX_BINS = 1024;
    localparam int SCORE_W       = 16;
    localparam int COORD_W       = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [COORD_W-1:0] GAIN_RST   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] OFFSET_RST = 32'h0000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN  = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_GAIN   = 2'd0,
        CFG_X_OFFSET = 2'd1,
        CFG_Y_GAIN   = 2'd2,
        CFG_Y_OFFSET = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      found;
    } t_kp_tag;

    typedef struct packed {
        logic b_en;
        logic c_en;
    } t_pipe_ctl;

endpackage

// ===== sv/skcd_argmax.sv =====
// Running arg-max per axis over the bin stream, plus keypoint candidate register.
// Depends on skcd_pkg.
module skcd_argmax #(
    parameter int MAX_BINS = skcd_pkg::SKCD_MAX_BINS,
    parameter int BW       = $clog2(MAX_BINS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_take,
    input  logic                                   i_adv,
    input  logic                                   i_kind,
    input  logic signed [skcd_pkg::SCORE_W-1:0]    i_score,
    input  logic                                   i_last,
    output logic                                   o_valid,
    output skcd_pkg::t_kp_tag                      o_tag,
    output logic        [BW:0]                     o_x_idx,
    output logic        [BW:0]                     o_y_idx
);
    import skcd_pkg::*;

    localparam logic [BW-1:0] BIN_TOP = BW'(MAX_BINS - 1);

    logic signed [SCORE_W-1:0] r_best_x, n_best_x, r_best_y, n_best_y;
    logic        [BW-1:0]      r_bin_x, n_bin_x, r_bin_y, n_bin_y;
    logic        [BW-1:0]      r_cnt, n_cnt;
    logic                      r_started, n_started;
    logic                      r_valid, n_valid;
    t_kp_tag                   r_tag, n_tag;
    logic        [BW:0]        r_x_idx, n_x_idx, r_y_idx, n_y_idx;
    logic        [BW-1:0]      w_idx;
    logic signed [SCORE_W-1:0] w_min;

    always_comb begin
        w_idx     = r_started ? r_cnt : '0;
        n_best_x  = r_best_x;
        n_bin_x   = r_bin_x;
        n_best_y  = r_best_y;
        n_bin_y   = r_bin_y;
        n_cnt     = r_cnt;
        n_started = r_started;
        if (i_take) begin
            if (i_kind) begin
                if (!r_started || i_score > r_best_y) begin
                    n_best_y = i_score;
                    n_bin_y  = w_idx;
                end
            end else begin
                if (!r_started || i_score > r_best_x) begin
                    n_best_x = i_score;
                    n_bin_x  = w_idx;
                end
            end
            if (i_last) begin
                n_started = 1'b0;
                n_cnt     = '0;
            end else begin
                n_started = 1'b1;
                n_cnt     = (w_idx < BIN_TOP) ? w_idx + 1'b1 : BIN_TOP;
            end
        end

        w_min       = (n_best_x > n_best_y) ? n_best_y : n_best_x;
        n_tag.score = w_min;
        n_tag.found = (w_min > 0);
        n_x_idx     = n_tag.found ? {1'b0, n_bin_x} : '1;
        n_y_idx     = n_tag.found ? {1'b0, n_bin_y} : '1;
        n_valid     = i_adv ? (i_take && i_kind && i_last) : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_x  <= '0;
            r_bin_x   <= '0;
            r_best_y  <= '0;
            r_bin_y   <= '0;
            r_cnt     <= '0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_best_x  <= n_best_x;
            r_bin_x   <= n_bin_x;
            r_best_y  <= n_best_y;
            r_bin_y   <= n_bin_y;
            r_cnt     <= n_cnt;
            r_started <= n_started;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag   <= n_tag;
            r_x_idx <= n_x_idx;
            r_y_idx <= n_y_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_x_idx = r_x_idx;
    assign o_y_idx = r_y_idx;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= BIN_TOP)
        else $error("bin counter beyond top bin");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> r_cnt == '0)
        else $error("bin counter nonzero outside a run");

    a_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_kind && i_last |=> r_valid)
        else $error("y run end did not raise a candidate");

endmodule

// ===== sv/skcd_coord_map.sv =====
// Bin index to image coordinate: registered multiply, then offset add and clamp.
// Depends on skcd_pkg.
module skcd_coord_map #(
    parameter int BW = $clog2(skcd_pkg::SKCD_MAX_BINS)
) (
    input  logic                                i_clk,
    input  skcd_pkg::t_pipe_ctl                 i_ctl,
    input  logic        [BW:0]                  i_idx,
    input  logic        [skcd_pkg::COORD_W-1:0] i_gain,
    input  logic        [skcd_pkg::COORD_W-1:0] i_offset,
    output logic        [skcd_pkg::COORD_W-1:0] o_coord
);
    import skcd_pkg::*;

    localparam int PW = BW + 1 + COORD_W + 1;

    logic [PW-1:0]      w_idx_ext, w_gain_ext, w_prod;
    logic [PW-1:0]      r_prod;
    logic [PW:0]        w_sum;
    logic [COORD_W-1:0] w_sat;
    logic [COORD_W-1:0] r_coord;

    assign w_idx_ext  = {{(PW-BW-1){i_idx[BW]}}, i_idx};
    assign w_gain_ext = {{(PW-COORD_W){1'b0}}, i_gain};
    assign w_prod     = w_idx_ext * w_gain_ext;

    always_comb begin
        w_sum = {r_prod[PW-1], r_prod}
              + {{(PW+1-COORD_W){i_offset[COORD_W-1]}}, i_offset};
        if (w_sum[PW:COORD_W-1] == '0 || w_sum[PW:COORD_W-1] == '1) begin
            w_sat = w_sum[COORD_W-1:0];
        end else begin
            w_sat = w_sum[PW] ? COORD_MIN : COORD_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.b_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.c_en) begin
            r_coord <= w_sat;
        end
    end

    assign o_coord = r_coord;

endmodule

// ===== sv/simcc_keypoint_decode_unit.sv =====
// Top level of the keypoint decode unit: config registers and pipeline control.
// Depends on skcd_pkg, skcd_argmax and skcd_coord_map.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one bin sample per request:
//   i_kind (0 = x bin, 1 = y bin), i_bin_score (Q8.8) and i_last_bin. For each
//   keypoint the x run comes first, then the y run. A y sample with i_last_bin
//   set ends the keypoint and yields one result request on the output channel
//   (o_valid / i_stall): o_x_coord, o_y_coord (Q16.16), o_score, o_found.
//   Other samples give no result.
//   Throughput: one sample per cycle while o_stall is low. The ending sample
//   passes the arg-max, multiply, and offset add and clamp registers before its
//   result is presented. The 11x33 coordinate multiply sets the pipeline split.
//   A stalled output holds its result; the stages behind it keep filling and
//   input is stalled only when all three are occupied.
//   Config writes (i_cfg_valid / o_cfg_ready, always ready) set gains and
//   offsets; the user must do them while no keypoint is in flight (unchecked).
//   Reset (synchronous, active low) sets gains to 1.0, offsets to 0, clears
//   running maxima, bin counter and pipeline.
module simcc_keypoint_decode_unit #(
    parameter int MAX_BINS = skcd_pkg::SKCD_MAX_BINS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_kind,
    input  logic signed [skcd_pkg::SCORE_W-1:0]    i_bin_score,
    input  logic                                   i_last_bin,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [skcd_pkg::COORD_W-1:0]    o_x_coord,
    output logic signed [skcd_pkg::COORD_W-1:0]    o_y_coord,
    output logic signed [skcd_pkg::SCORE_W-1:0]    o_score,
    output logic                                   o_found,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [skcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [skcd_pkg::COORD_W-1:0]    i_cfg_data
);
    import skcd_pkg::*;

    localparam int BW = $clog2(MAX_BINS);

    logic [COORD_W-1:0] r_x_gain, r_x_offset, r_y_gain, r_y_offset;
    logic               w_take, w_a_adv, w_b_adv, w_c_take;
    logic               w_a_valid;
    logic               r_b_valid, r_c_valid;
    t_kp_tag            w_a_tag, r_b_tag, r_c_tag;
    logic [BW:0]        w_x_idx, w_y_idx;
    t_pipe_ctl          w_ctl;
    logic [COORD_W-1:0] w_x_coord, w_y_coord;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain   <= GAIN_RST;
            r_x_offset <= OFFSET_RST;
            r_y_gain   <= GAIN_RST;
            r_y_offset <= OFFSET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_X_GAIN:   r_x_gain   <= i_cfg_data;
                CFG_X_OFFSET: r_x_offset <= i_cfg_data;
                CFG_Y_GAIN:   r_y_gain   <= i_cfg_data;
                CFG_Y_OFFSET: r_y_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_c_take = !r_c_valid || !i_stall;
    assign w_b_adv  = !r_b_valid || w_c_take;
    assign w_a_adv  = !w_a_valid || w_b_adv;
    assign o_stall  = !w_a_adv;
    assign w_take   = i_valid && w_a_adv;

    assign w_ctl.b_en = w_b_adv;
    assign w_ctl.c_en = w_c_take;

    skcd_argmax #(
        .MAX_BINS (MAX_BINS),
        .BW       (BW)
    ) u_argmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_adv   (w_a_adv),
        .i_kind  (i_kind),
        .i_score (i_bin_score),
        .i_last  (i_last_bin),
        .o_valid (w_a_valid),
        .o_tag   (w_a_tag),
        .o_x_idx (w_x_idx),
        .o_y_idx (w_y_idx)
    );

    skcd_coord_map #(.BW(BW)) u_map_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_idx    (w_x_idx),
        .i_gain   (r_x_gain),
        .i_offset (r_x_offset),
        .o_coord  (w_x_coord)
    );

    skcd_coord_map #(.BW(BW)) u_map_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_idx    (w_y_idx),
        .i_gain   (r_y_gain),
        .i_offset (r_y_offset),
        .o_coord  (w_y_coord)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_b_adv) begin
                r_b_valid <= w_a_valid;
            end
            if (w_c_take) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_adv) begin
            r_b_tag <= w_a_tag;
        end
        if (w_c_take) begin
            r_c_tag <= r_b_tag;
        end
    end

    assign o_valid   = r_c_valid;
    assign o_x_coord = w_x_coord;
    assign o_y_coord = w_y_coord;
    assign o_score   = r_c_tag.score;
    assign o_found   = r_c_tag.found;

    a_found_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_found == (o_score > 0)))
        else $error("found flag disagrees with score");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_a_valid && r_b_valid && r_c_valid))
        else $error("input stalled with a free stage");

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !w_b_adv |=> r_b_valid)
        else $error("multiply stage dropped a held result");

endmodule
